>>> rtl/cpu_alu_with_flags_defines.svh
// assertion macros shared by the alu rtl
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define ALU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alu assertion failed");
// check a property on every clock edge, reset included
`define ALU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("alu assertion failed during reset");
`else
`define ALU_ASSERT(label, prop)
`define ALU_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/cpualu_pkg.sv
// types and operation codes of the alu
`default_nettype none

package cpualu_pkg;

  // operation codes
  localparam logic [4:0] FUNC_ADD   = 5'd0;
  localparam logic [4:0] FUNC_ADC   = 5'd1;
  localparam logic [4:0] FUNC_SUB   = 5'd2;
  localparam logic [4:0] FUNC_SBC   = 5'd3;
  localparam logic [4:0] FUNC_AND   = 5'd4;
  localparam logic [4:0] FUNC_OR    = 5'd5;
  localparam logic [4:0] FUNC_XOR   = 5'd6;
  localparam logic [4:0] FUNC_INC   = 5'd7;
  localparam logic [4:0] FUNC_DEC   = 5'd8;
  localparam logic [4:0] FUNC_ADD16 = 5'd9;
  localparam logic [4:0] FUNC_ADDSP = 5'd10;
  localparam logic [4:0] FUNC_DAA   = 5'd11;
  localparam logic [4:0] FUNC_BIT   = 5'd12;
  localparam logic [4:0] FUNC_SLA   = 5'd13;
  localparam logic [4:0] FUNC_SRL   = 5'd14;
  localparam logic [4:0] FUNC_SRA   = 5'd15;
  localparam logic [4:0] FUNC_RLC   = 5'd16;
  localparam logic [4:0] FUNC_RL    = 5'd17;
  localparam logic [4:0] FUNC_RRC   = 5'd18;
  localparam logic [4:0] FUNC_RR    = 5'd19;
  localparam logic [4:0] FUNC_SWAP  = 5'd20;

  // flag positions in the packed z n h c nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;

  typedef struct packed {
    logic [4:0]  func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        bit_tested;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/cpu_alu_with_flags.sv
// sm83 style alu with flags, input register and result register
//
//   channel  | valid       | stall       | request
//   ---------+-------------+-------------+------------
//   input    | in_valid_i  | in_stall_o  | in_req_i
//   output   | out_valid_o | out_stall_i | out_req_o
//
// an accepted request passes through the input register and then the result
// register before it reaches the output. one request is taken per cycle while
// in_stall_o is low; the single pass of alu logic between the two registers sets that.
// reset clears both valid bits. an output stall holds the result register and
// stalls the input only once the input register is also full.
`default_nettype none
`include "cpu_alu_with_flags_defines.svh"

module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire alu_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output alu_rsp_t      out_req_o
);

  logic     req_valid_q;
  alu_req_t req_q;
  logic     rsp_valid_q;
  alu_rsp_t rsp_q;
  logic     out_free;
  logic     in_take;
  alu_rsp_t rsp_d;

  // pipeline flow control
  assign out_free   = !rsp_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!req_valid_q || out_free) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
  end

  // operand slices
  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        carry_c;
  logic        borrow_c;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [16:0] add16_sum;
  logic [12:0] add16_half;
  logic [15:0] addsp_sum;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_res;
  logic        daa_c;

  assign a   = req_q.operand_a[7:0];
  assign b   = req_q.operand_b[7:0];
  assign cin = req_q.flags_in[FLAG_C];

  // carry in only for adc and sbc
  assign carry_c  = (req_q.func == FUNC_ADC) ? cin : 1'b0;
  assign borrow_c = (req_q.func == FUNC_SBC) ? cin : 1'b0;

  // 8-bit adder and subtractor with nibble carries
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, carry_c};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_c};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, borrow_c};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, borrow_c};

  // 16-bit adds
  assign add16_sum  = {1'b0, req_q.operand_a} + {1'b0, req_q.operand_b};
  assign add16_half = {1'b0, req_q.operand_a[11:0]} + {1'b0, req_q.operand_b[11:0]};
  assign addsp_sum  = req_q.operand_a + {{8{b[7]}}, b};

  // decimal adjust
  always_comb begin
    daa_adj = 8'd0;
    daa_c   = cin;
    if (req_q.flags_in[FLAG_N]) begin
      if (req_q.flags_in[FLAG_H]) daa_adj = daa_adj | DAA_LO_ADJ;
      if (req_q.flags_in[FLAG_C]) daa_adj = daa_adj | DAA_HI_ADJ;
      daa_res = a - daa_adj;
    end else begin
      daa_c = 1'b0;
      if (req_q.flags_in[FLAG_H] || (a[3:0] > DAA_LO_MAX)) daa_adj = daa_adj | DAA_LO_ADJ;
      if (req_q.flags_in[FLAG_C] || (a > DAA_HI_MAX)) begin
        daa_adj = daa_adj | DAA_HI_ADJ;
        daa_c   = 1'b1;
      end
      daa_res = a + daa_adj;
    end
  end

  // result and flag select
  always_comb begin
    logic [7:0] r8;
    r8              = 8'd0;
    rsp_d.result    = 16'd0;
    rsp_d.flags_out = req_q.flags_in;
    rsp_d.bit_tested = 1'b0;
    case (req_q.func)
      FUNC_ADD, FUNC_ADC: begin
        r8 = add_sum[7:0];
        rsp_d.flags_out = {r8 == 8'd0, 1'b0, add_half[4], add_sum[8]};
      end
      FUNC_SUB, FUNC_SBC: begin
        r8 = sub_diff[7:0];
        rsp_d.flags_out = {r8 == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
      end
      FUNC_AND: begin
        r8 = a & b;
        rsp_d.flags_out = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      FUNC_OR: begin
        r8 = a | b;
        rsp_d.flags_out = {r8 == 8'd0, 3'b000};
      end
      FUNC_XOR: begin
        r8 = a ^ b;
        rsp_d.flags_out = {r8 == 8'd0, 3'b000};
      end
      FUNC_INC: begin
        r8 = b + 8'd1;
        rsp_d.flags_out = {r8 == 8'd0, 1'b0, b[3:0] == 4'hF, cin};
      end
      FUNC_DEC: begin
        r8 = b - 8'd1;
        rsp_d.flags_out = {r8 == 8'd0, 1'b1, b[3:0] == 4'h0, cin};
      end
      FUNC_DAA: begin
        r8 = daa_res;
        rsp_d.flags_out = {r8 == 8'd0, req_q.flags_in[FLAG_N], 1'b0, daa_c};
      end
      FUNC_BIT: begin
        rsp_d.bit_tested = b[req_q.bit_index];
        rsp_d.flags_out  = {!b[req_q.bit_index], 1'b0, 1'b1, cin};
      end
      FUNC_SLA: begin
        r8 = {b[6:0], 1'b0};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[7]};
      end
      FUNC_SRL: begin
        r8 = {1'b0, b[7:1]};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[0]};
      end
      FUNC_SRA: begin
        r8 = {b[7], b[7:1]};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[0]};
      end
      FUNC_RLC: begin
        r8 = {b[6:0], b[7]};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[7]};
      end
      FUNC_RL: begin
        r8 = {b[6:0], cin};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[7]};
      end
      FUNC_RRC: begin
        r8 = {b[0], b[7:1]};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[0]};
      end
      FUNC_RR: begin
        r8 = {cin, b[7:1]};
        rsp_d.flags_out = {r8 == 8'd0, 2'b00, b[0]};
      end
      FUNC_SWAP: begin
        r8 = {b[3:0], b[7:4]};
        rsp_d.flags_out = {r8 == 8'd0, 3'b000};
      end
      default: begin
        r8 = 8'd0;
      end
    endcase
    rsp_d.result = {8'd0, r8};
    // 16-bit operations override the byte result
    if (req_q.func == FUNC_ADD16) begin
      rsp_d.result    = add16_sum[15:0];
      rsp_d.flags_out = {req_q.flags_in[FLAG_Z], 1'b0, add16_half[12], add16_sum[16]};
    end else if (req_q.func == FUNC_ADDSP) begin
      rsp_d.result    = addsp_sum;
      rsp_d.flags_out = {2'b00, add_half[4], add_sum[8]};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_req_o   = rsp_q;

  // checks
  `ALU_ASSERT(stall_only_when_full, in_stall_o |-> (req_valid_q && rsp_valid_q && out_stall_i))
  `ALU_ASSERT(take_lands_in_reg, in_take |=> (req_valid_q && (req_q == $past(in_req_i))))
  `ALU_ASSERT(reg_moves_to_out, (req_valid_q && out_free) |=> (out_valid_o && (rsp_q == $past(rsp_d))))
  `ALU_ASSERT(bit_only_on_test, (req_valid_q && rsp_d.bit_tested) |-> (req_q.func == FUNC_BIT))
  `ALU_ASSERT_ALWAYS(reset_empties, !rst_ni |=> (!req_valid_q && !rsp_valid_q))

endmodule

`default_nettype wire

>>> bench/tb.sv
// self-checking testbench for the sm83 style alu with flags
`default_nettype none

module tb;
  import cpualu_pkg::*;

  localparam int unsigned ITEM_TOTAL   = 1150;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [4:0]  FUNC_FIRST_UNUSED = FUNC_SWAP + 5'd1;
  localparam logic [4:0]  FUNC_LAST_CODE    = 5'h1F;
  localparam logic [7:0]  EDGE_BYTES [10] =
    '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  alu_req_t in_req_i    = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  alu_rsp_t out_req_o;

  alu_req_t req_backlog[$];
  alu_rsp_t pending_results[$];
  alu_rsp_t want_rsp;
  int unsigned req_total    = 0;
  int unsigned req_taken    = 0;
  int unsigned rsp_seen     = 0;
  int unsigned mismatches   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned input_stalls = 0;
  logic        hold_done    = 1'b0;
  logic [31:0] func_seen    = '0;

  cpu_alu_with_flags i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // pack z n h c at their package positions
  function automatic logic [3:0] make_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // expected result, flags and tested bit of one request
  function automatic alu_rsp_t alu_compute(alu_req_t rq);
    logic [7:0]  a8, b8, r8, adj;
    logic [8:0]  wide8;
    logic [4:0]  low5;
    logic [16:0] wide16;
    logic [12:0] low13;
    logic        cin, cy;
    alu_rsp_t    rs;
    a8  = rq.operand_a[7:0];
    b8  = rq.operand_b[7:0];
    cin = rq.flags_in[FLAG_C];
    rs  = '0;
    rs.flags_out = rq.flags_in;
    r8  = '0;
    cy  = 1'b0;
    case (rq.func)
      FUNC_ADD, FUNC_ADC: begin
        cy    = (rq.func == FUNC_ADC) && cin;
        wide8 = {1'b0, a8} + {1'b0, b8} + {8'd0, cy};
        low5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cy};
        r8    = wide8[7:0];
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, low5[4], wide8[8]);
      end
      FUNC_SUB, FUNC_SBC: begin
        cy    = (rq.func == FUNC_SBC) && cin;
        r8    = a8 - b8 - {7'd0, cy};
        low5  = {1'b0, b8[3:0]} + {4'd0, cy};
        wide8 = {1'b0, b8} + {8'd0, cy};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b1, {1'b0, a8[3:0]} < low5,
                                  {1'b0, a8} < wide8);
      end
      FUNC_AND: begin
        r8 = a8 & b8;
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      FUNC_OR: begin
        r8 = a8 | b8;
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      FUNC_XOR: begin
        r8 = a8 ^ b8;
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      FUNC_INC: begin
        r8 = b8 + 8'd1;
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, b8[3:0] == 4'hF, cin);
      end
      FUNC_DEC: begin
        r8 = b8 - 8'd1;
        rs.flags_out = make_flags(r8 == 8'h00, 1'b1, b8[3:0] == 4'h0, cin);
      end
      FUNC_ADD16: begin
        wide16    = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
        low13     = {1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]};
        rs.result = wide16[15:0];
        rs.flags_out = make_flags(rq.flags_in[FLAG_Z], 1'b0, low13[12], wide16[16]);
      end
      FUNC_ADDSP: begin
        rs.result = rq.operand_a + {{8{b8[7]}}, b8};
        low5  = {1'b0, rq.operand_a[3:0]} + {1'b0, b8[3:0]};
        wide8 = {1'b0, rq.operand_a[7:0]} + {1'b0, b8};
        rs.flags_out = make_flags(1'b0, 1'b0, low5[4], wide8[8]);
      end
      FUNC_DAA: begin
        adj = '0;
        if (rq.flags_in[FLAG_N]) begin
          // after a subtract only the flagged corrections apply, carry kept
          if (rq.flags_in[FLAG_H]) adj = adj + DAA_LO_ADJ;
          if (cin) adj = adj + DAA_HI_ADJ;
          r8 = a8 - adj;
          cy = cin;
        end else begin
          if (rq.flags_in[FLAG_H] || a8[3:0] > DAA_LO_MAX) adj = adj + DAA_LO_ADJ;
          if (cin || a8 > DAA_HI_MAX) begin
            adj = adj + DAA_HI_ADJ;
            cy  = 1'b1;
          end
          r8 = a8 + adj;
        end
        rs.flags_out = make_flags(r8 == 8'h00, rq.flags_in[FLAG_N], 1'b0, cy);
      end
      FUNC_BIT: begin
        rs.bit_tested = b8[rq.bit_index];
        rs.flags_out  = make_flags(!b8[rq.bit_index], 1'b0, 1'b1, cin);
      end
      FUNC_SLA: begin
        r8 = {b8[6:0], 1'b0};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[7]);
      end
      FUNC_SRL: begin
        r8 = {1'b0, b8[7:1]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[0]);
      end
      FUNC_SRA: begin
        r8 = {b8[7], b8[7:1]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[0]);
      end
      FUNC_RLC: begin
        r8 = {b8[6:0], b8[7]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[7]);
      end
      FUNC_RL: begin
        r8 = {b8[6:0], cin};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[7]);
      end
      FUNC_RRC: begin
        r8 = {b8[0], b8[7:1]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[0]);
      end
      FUNC_RR: begin
        r8 = {cin, b8[7:1]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, b8[0]);
      end
      FUNC_SWAP: begin
        r8 = {b8[3:0], b8[7:4]};
        rs.flags_out = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    // byte-wide operations return the low byte with the high byte cleared
    if (rq.func != FUNC_ADD16 && rq.func != FUNC_ADDSP) rs.result = {8'h00, r8};
    return rs;
  endfunction

  function automatic void queue_req(logic [4:0] fn, logic [15:0] a, logic [15:0] b,
                                    logic [2:0] idx, logic [3:0] fl);
    alu_req_t rq;
    rq.func      = fn;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.bit_index = idx;
    rq.flags_in  = fl;
    req_backlog.push_back(rq);
  endfunction

  // byte biased toward carry and decimal edges
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 3) return EDGE_BYTES[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  // idle length: mostly none or short, a few long, none in quiet stretches
  function automatic int unsigned draw_gap(logic quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // request driver, records the expected result of every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(alu_compute(in_req_i));
        func_seen[in_req_i.func] <= 1'b1;
        req_taken <= req_taken + 1;
      end
      if (in_valid_i && in_stall_o) begin
        input_stalls <= input_stalls + 1;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (req_backlog.size() > 0) begin
        in_req_i   <= req_backlog.pop_front();
        in_valid_i <= 1'b1;
        gap_left   <= draw_gap(((req_taken / 64) % 4) == 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        rsp_seen <= rsp_seen + 1;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result %h flags %h bit %b", out_req_o.result,
                     out_req_o.flags_out, out_req_o.bit_tested);
        end else begin
          want_rsp = pending_results.pop_front();
          if (want_rsp.result !== out_req_o.result ||
              want_rsp.flags_out !== out_req_o.flags_out ||
              want_rsp.bit_tested !== out_req_o.bit_tested) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result #%0d: expected %h/%h/%b got %h/%h/%b (result/flags/bit)",
                       rsp_seen, want_rsp.result, want_rsp.flags_out, want_rsp.bit_tested,
                       out_req_o.result, out_req_o.flags_out, out_req_o.bit_tested);
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && rsp_seen == HOLD_AT) begin
        hold_done   <= 1'b1;
        out_stall_i <= 1'b1;
        stall_left  <= LONG_HOLD;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        automatic int unsigned g = draw_gap(((rsp_seen / 64) % 4) == 1);
        out_stall_i <= (g != 0);
        stall_left  <= (g != 0) ? g - 1 : 0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus, end of run and verdict
  initial begin
    alu_req_t    rq;
    alu_rsp_t    rs;
    int unsigned directed;
    int unsigned sel;

    // directed: operand extremes, every operation, unused codes
    queue_req(FUNC_ADD,   16'h12FF, 16'hAB01, 3'd0, 4'h0);
    queue_req(FUNC_ADC,   16'h000F, 16'h0000, 3'd0, 4'h1);
    queue_req(FUNC_SUB,   16'hFF00, 16'h0001, 3'd0, 4'h0);
    queue_req(FUNC_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1);
    queue_req(FUNC_AND,   16'h00F0, 16'hFF0F, 3'd0, 4'hF);
    queue_req(FUNC_OR,    16'hFF00, 16'h0000, 3'd0, 4'hF);
    queue_req(FUNC_XOR,   16'h00FF, 16'h00FF, 3'd0, 4'h0);
    queue_req(FUNC_INC,   16'h0000, 16'hFFFF, 3'd0, 4'h1);
    queue_req(FUNC_DEC,   16'h0000, 16'h0000, 3'd0, 4'h0);
    queue_req(FUNC_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8);
    queue_req(FUNC_ADD16, 16'hFFFF, 16'hFFFF, 3'd0, 4'h0);
    queue_req(FUNC_ADDSP, 16'hFFF8, 16'h0008, 3'd0, 4'hF);
    queue_req(FUNC_ADDSP, 16'h0000, 16'hFF80, 3'd0, 4'h0);
    queue_req(FUNC_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0);
    queue_req(FUNC_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7);
    queue_req(FUNC_BIT,   16'h0000, 16'h0080, 3'd7, 4'h1);
    queue_req(FUNC_BIT,   16'h0000, 16'h00FE, 3'd0, 4'h0);
    queue_req(FUNC_SLA,   16'h0000, 16'h0080, 3'd0, 4'h0);
    queue_req(FUNC_SRL,   16'h0000, 16'h0001, 3'd0, 4'hF);
    queue_req(FUNC_SRA,   16'h0000, 16'h0081, 3'd0, 4'h0);
    queue_req(FUNC_RLC,   16'h0000, 16'h0080, 3'd0, 4'h0);
    queue_req(FUNC_RL,    16'h0000, 16'h0080, 3'd0, 4'h1);
    queue_req(FUNC_RRC,   16'h0000, 16'h0001, 3'd0, 4'h0);
    queue_req(FUNC_RR,    16'h0000, 16'h0001, 3'd0, 4'h0);
    queue_req(FUNC_SWAP,  16'h0000, 16'h00F0, 3'd0, 4'hF);
    queue_req(FUNC_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'hA);
    queue_req(FUNC_LAST_CODE,    16'h1234, 16'h5678, 3'd3, 4'h5);
    directed = req_backlog.size();

    // random: bcd add or subtract followed by a decimal adjust, or a lone op
    while (req_backlog.size() < ITEM_TOTAL) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        rq.func      = FUNC_ADD + 5'($urandom_range(0, 3));
        rq.operand_a = {pick_byte(), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        rq.operand_b = {pick_byte(), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        rq.bit_index = 3'($urandom_range(0, 7));
        rq.flags_in  = 4'($urandom_range(0, 15));
        req_backlog.push_back(rq);
        rs = alu_compute(rq);
        rq.func      = FUNC_DAA;
        rq.operand_a = {pick_byte(), rs.result[7:0]};
        rq.operand_b = 16'($urandom_range(0, 65535));
        rq.bit_index = 3'($urandom_range(0, 7));
        rq.flags_in  = rs.flags_out;
        req_backlog.push_back(rq);
      end else begin
        if ($urandom_range(0, 19) == 0)
          rq.func = 5'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_CODE));
        else
          rq.func = 5'($urandom_range(FUNC_ADD, FUNC_SWAP));
        rq.operand_a = {pick_byte(), pick_byte()};
        rq.operand_b = {pick_byte(), pick_byte()};
        rq.bit_index = 3'($urandom_range(0, 7));
        rq.flags_in  = 4'($urandom_range(0, 15));
        req_backlog.push_back(rq);
      end
    end
    req_total = req_backlog.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_taken != req_total || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests (%0d directed) over %0d of 32 operation codes, %0d results checked",
             req_taken, directed, $countones(func_seen), rsp_seen);
    $display("input stalled for %0d cycles, %0d mismatches", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> cpu_alu_with_flags.f
+incdir+rtl
rtl/cpualu_pkg.sv
rtl/cpu_alu_with_flags.sv
bench/tb.sv
